### design/spq_pkg.sv
// ============================================================================
// spq_pkg
// Shared types and codes of the sorted priority queue.
// ============================================================================
package spq_pkg;

   localparam int DATA_W = 32;
   localparam int FILL_W = 5;

   // operation codes carried in the kind field
   localparam logic KIND_ENQ = 1'b0;
   localparam logic KIND_DEQ = 1'b1;

   // one stored entry: data value and its priority
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
   } spq_entry_type;

endpackage

### design/spq_if.sv
// ============================================================================
// spq_if
// Valid/ready channels of the sorted priority queue: request and response.
// ============================================================================
interface spq_req_if;
   import spq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic signed [DATA_W-1:0] value;
   logic signed [DATA_W-1:0] prio;

   modport source (output valid, output kind, output value, output prio, input ready);
   modport sink   (input valid, input kind, input value, input prio, output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] front_value;
   logic signed [DATA_W-1:0] front_prio;
   logic signed [DATA_W-1:0] rear_value;
   logic        [FILL_W-1:0] fill_count;
   logic                     is_empty;
   logic                     underflow;
   logic                     overflow;

   modport source (output valid, output front_value, output front_prio, output rear_value,
                   output fill_count, output is_empty, output underflow, output overflow,
                   input ready);
   modport sink   (input valid, input front_value, input front_prio, input rear_value,
                   input fill_count, input is_empty, input underflow, input overflow,
                   output ready);
endinterface

### design/spq_mem.sv
// ============================================================================
// spq_mem
// Entry storage: one write port, one read port with registered read data.
// ============================================================================
module spq_mem #(
   parameter int DEPTH = 16,
   parameter int IW    = 4
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [IW-1:0]          wr_addr,
   input  spq_pkg::spq_entry_type wr_data,
   input  logic [IW-1:0]          rd_addr,
   output spq_pkg::spq_entry_type rd_data
);
   import spq_pkg::*;

   spq_entry_type mem_ff [DEPTH];
   spq_entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/spq_seq.sv
// ============================================================================
// spq_seq
// Sequencer: ring pointers, insertion scan with the shared priority
// comparator, head reload on dequeue, and the response word register.
// ============================================================================
module spq_seq #(
   parameter int DEPTH = 16,
   parameter int IW    = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   spq_req_if.sink                req_bus,
   spq_rsp_if.source              rsp_bus,
   output logic                   mem_we,
   output logic [IW-1:0]          mem_waddr,
   output spq_pkg::spq_entry_type mem_wdata,
   output logic [IW-1:0]          mem_raddr,
   input  spq_pkg::spq_entry_type mem_rdata
);
   import spq_pkg::*;

   localparam int              CW      = $clog2(DEPTH + 1);
   localparam logic [CW-1:0]   DEPTH_C = CW'(DEPTH);
   localparam logic [IW:0]     DEPTH_W = (IW + 1)'(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_CMP,
      S_DEQ_READ,
      S_DEQ_LOAD,
      S_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic [IW-1:0]            head_ff, head_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [IW-1:0]            pos_ff, pos_in;
   spq_entry_type            new_ff, new_in;
   spq_entry_type            front_ff, front_in;
   logic signed [DATA_W-1:0] rear_ff, rear_in;
   logic                     under_ff, under_in;
   logic                     over_ff, over_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_front_value_ff, rsp_front_value_in;
   logic signed [DATA_W-1:0] rsp_front_prio_ff, rsp_front_prio_in;
   logic signed [DATA_W-1:0] rsp_rear_value_ff, rsp_rear_value_in;
   logic [FILL_W-1:0]        rsp_fill_ff, rsp_fill_in;
   logic                     rsp_empty_ff, rsp_empty_in;
   logic                     rsp_under_ff, rsp_under_in;
   logic                     rsp_over_ff, rsp_over_in;

   logic [IW-1:0]            pos_m1;
   logic [IW-1:0]            phys_pos;
   logic [IW-1:0]            phys_pos_m1;
   logic                     ins_done;
   logic [CW+FILL_W-1:0]     fill_wide;

   // ring index: head plus logical offset, folded once below DEPTH
   function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                              input logic [IW-1:0] offs);
      logic [IW:0] sum;
      begin
         sum = {1'b0, base} + {1'b0, offs};
         if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
         end
         wrap_add = sum[IW-1:0];
      end
   endfunction

   assign pos_m1      = pos_ff - IW'(1);
   assign phys_pos    = wrap_add(head_ff, pos_ff);
   assign phys_pos_m1 = wrap_add(head_ff, pos_m1);
   assign fill_wide   = {{FILL_W{1'b0}}, count_ff};

   assign req_bus.ready = (state_ff == S_IDLE);

   // next-state logic
   always_comb begin
      state_in           = state_ff;
      head_in            = head_ff;
      count_in           = count_ff;
      pos_in             = pos_ff;
      new_in             = new_ff;
      front_in           = front_ff;
      rear_in            = rear_ff;
      under_in           = under_ff;
      over_in            = over_ff;
      rsp_valid_in       = rsp_valid_ff & ~rsp_bus.ready;
      rsp_front_value_in = rsp_front_value_ff;
      rsp_front_prio_in  = rsp_front_prio_ff;
      rsp_rear_value_in  = rsp_rear_value_ff;
      rsp_fill_in        = rsp_fill_ff;
      rsp_empty_in       = rsp_empty_ff;
      rsp_under_in       = rsp_under_ff;
      rsp_over_in        = rsp_over_ff;
      mem_we             = 1'b0;
      mem_waddr          = phys_pos;
      mem_wdata          = new_ff;
      mem_raddr          = phys_pos_m1;
      ins_done           = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               under_in = 1'b0;
               over_in  = 1'b0;
               if (req_bus.kind == KIND_ENQ) begin
                  if (count_ff == DEPTH_C) begin
                     // full: drop the word
                     over_in  = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     new_in.value = req_bus.value;
                     new_in.prio  = req_bus.prio;
                     pos_in       = count_ff[IW-1:0];
                     state_in     = S_SCAN;
                  end
               end else begin
                  if (count_ff == '0) begin
                     under_in = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     head_in  = wrap_add(head_ff, IW'(1));
                     count_in = count_ff - CW'(1);
                     state_in = (count_ff == CW'(1)) ? S_DONE : S_DEQ_READ;
                  end
               end
            end
         end

         // reached the head, or fetch the entry in front of the hole
         S_SCAN: begin
            if (pos_ff == '0) begin
               mem_we   = 1'b1;
               ins_done = 1'b1;
            end else begin
               state_in = S_CMP;
            end
         end

         // shared comparator: move the entry up if it ranks behind the new one
         S_CMP: begin
            mem_we = 1'b1;
            if ($signed(mem_rdata.prio) > $signed(new_ff.prio)) begin
               mem_wdata = mem_rdata;
               pos_in    = pos_m1;
               state_in  = S_SCAN;
            end else begin
               ins_done = 1'b1;
            end
         end

         S_DEQ_READ: begin
            mem_raddr = head_ff;
            state_in  = S_DEQ_LOAD;
         end

         S_DEQ_LOAD: begin
            front_in = mem_rdata;
            state_in = S_DONE;
         end

         // load the response word once the output register is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               if (count_ff == '0) begin
                  rsp_front_value_in = '0;
                  rsp_front_prio_in  = '0;
                  rsp_rear_value_in  = '0;
               end else begin
                  rsp_front_value_in = front_ff.value;
                  rsp_front_prio_in  = front_ff.prio;
                  rsp_rear_value_in  = rear_ff;
               end
               rsp_fill_in  = fill_wide[FILL_W-1:0];
               rsp_empty_in = (count_ff == '0);
               rsp_under_in = under_ff;
               rsp_over_in  = over_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // insertion written: update count and the cached head and tail
      if (ins_done) begin
         count_in = count_ff + CW'(1);
         if (pos_ff == '0) begin
            front_in = new_ff;
         end
         if (CW'(pos_ff) == count_ff) begin
            rear_in = new_ff.value;
         end
         state_in = S_DONE;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      pos_ff             <= pos_in;
      new_ff             <= new_in;
      front_ff           <= front_in;
      rear_ff            <= rear_in;
      under_ff           <= under_in;
      over_ff            <= over_in;
      rsp_front_value_ff <= rsp_front_value_in;
      rsp_front_prio_ff  <= rsp_front_prio_in;
      rsp_rear_value_ff  <= rsp_rear_value_in;
      rsp_fill_ff        <= rsp_fill_in;
      rsp_empty_ff       <= rsp_empty_in;
      rsp_under_ff       <= rsp_under_in;
      rsp_over_ff        <= rsp_over_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.front_value = rsp_front_value_ff;
   assign rsp_bus.front_prio  = rsp_front_prio_ff;
   assign rsp_bus.rear_value  = rsp_rear_value_ff;
   assign rsp_bus.fill_count  = rsp_fill_ff;
   assign rsp_bus.is_empty    = rsp_empty_ff;
   assign rsp_bus.underflow   = rsp_under_ff;
   assign rsp_bus.overflow    = rsp_over_ff;

endmodule

### design/sorted_priority_queue_top.sv
// ============================================================================
// sorted_priority_queue_top
// Bounded priority queue kept sorted by ascending priority, ties in arrival
// order, with one response word per request word.
// ============================================================================
// Entries live in a DEPTH-entry ring memory, head first. A dequeue advances
// the head pointer and reloads the cached head entry from memory through
// S_DEQ_READ and S_DEQ_LOAD, unless it leaves the queue empty or underflows,
// which goes straight to S_DONE. An enqueue scans from the tail toward the
// head with one signed priority comparator, moving each entry that ranks
// behind the new one up by a slot; each moved entry takes a memory read, then
// a compare and write back. A dropped enqueue on a full queue goes straight
// to S_DONE. One request is worked on at a time; a new request is taken while
// the previous response still waits on rsp_bus. Storage needs no clearing
// after reset: only slots below the fill count are ever read.
// ============================================================================
module sorted_priority_queue_top #(
   parameter int DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_bus,
   spq_rsp_if.source rsp_bus
);
   import spq_pkg::*;

   localparam int IW = $clog2(DEPTH);

   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   spq_entry_type mem_wdata;
   logic [IW-1:0] mem_raddr;
   spq_entry_type mem_rdata;

   // sequencer with the shared comparator
   spq_seq #(
      .DEPTH (DEPTH),
      .IW    (IW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // entry ring storage
   spq_mem #(
      .DEPTH (DEPTH),
      .IW    (IW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule
